// ===== sv/spra_pkg.sv =====
`default_nettype none

package spra_pkg;

    localparam int BASIC_SLOTS    = 8;
    localparam int DATAGRAM_SLOTS = 8;
    localparam int SNIP_SLOTS     = 8;
    localparam int STREAM_SLOTS   = 8;
    localparam int REF_BITS       = 8;

    localparam int TOTAL_SLOTS = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS + STREAM_SLOTS;
    localparam int POOL_MAX    = 16;
    localparam int OFF_W       = $clog2(POOL_MAX);
    localparam int SLOT_AW     = $clog2(TOTAL_SLOTS);

    localparam int CMD_W    = 3;
    localparam int POOL_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int REFO_W   = 8;
    localparam int CNT_W    = 5;
    localparam int NPOOLS   = 4;

    typedef logic [REF_BITS-1:0] t_refs;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [POOL_W-1:0]   t_pool;

    localparam t_refs REF_MAX = {REF_BITS{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_ADDREF  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_REPORT  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_SAT      = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    function automatic t_slot pool_base(input t_pool p);
        t_slot b;
        unique case (p)
            2'd0: b = '0;
            2'd1: b = SLOT_W'(BASIC_SLOTS);
            2'd2: b = SLOT_W'(BASIC_SLOTS + DATAGRAM_SLOTS);
            default: b = SLOT_W'(BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS);
        endcase
        return b;
    endfunction

    function automatic t_cnt pool_size(input t_pool p);
        t_cnt s;
        unique case (p)
            2'd0: s = CNT_W'(BASIC_SLOTS);
            2'd1: s = CNT_W'(DATAGRAM_SLOTS);
            2'd2: s = CNT_W'(SNIP_SLOTS);
            default: s = CNT_W'(STREAM_SLOTS);
        endcase
        return s;
    endfunction

    function automatic t_pool pool_of(input t_slot s);
        t_pool p;
        if (s >= pool_base(2'd3)) begin
            p = 2'd3;
        end else if (s >= pool_base(2'd2)) begin
            p = 2'd2;
        end else if (s >= pool_base(2'd1)) begin
            p = 2'd1;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/segregated_pool_refcount_allocator_core.sv =====
`default_nettype none

// Reference-counted slot manager over four consecutive slot pools.
// A command word (i_cmd, i_pool_type, i_slot_index) is taken at a clock edge
// where start is high and busy is low. The block then raises busy for one
// cycle while it updates the slot's reference count, read from the count
// memory at the accepting edge, and writes it back together with the
// allocated flags and the per-pool live and peak counters.
// Exactly one result word follows every command: it is put on the o_ ports
// at the edge that ends the busy cycle and marked by o_valid. The receiver
// cannot stall, so no result is ever held back.
// No new command is taken while busy: the count memory read at the accepting
// edge is followed by the write-back in the busy cycle. A new command
// may be taken in the cycle its predecessor's result is shown.
// Allocation picks the lowest free slot of the pool with a priority search
// over that pool's allocated flags.
// Reset clears all allocated flags, live and peak counters and the state
// machine at once; the count memory needs no clearing since an entry is only
// read after an allocation has written it.
module segregated_pool_refcount_allocator_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [spra_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [spra_pkg::POOL_W-1:0]    i_pool_type,
    input  wire logic [spra_pkg::SLOT_W-1:0]    i_slot_index,
    output logic                                o_valid,
    output logic [spra_pkg::STATUS_W-1:0]       o_status,
    output logic [spra_pkg::SLOT_W-1:0]         o_granted_slot,
    output logic [spra_pkg::REFO_W-1:0]         o_ref_count_after,
    output logic                                o_slot_freed,
    output logic [spra_pkg::POOL_W-1:0]         o_pool_reported,
    output logic [spra_pkg::CNT_W-1:0]          o_live_count,
    output logic [spra_pkg::CNT_W-1:0]          o_peak_count
);
    import spra_pkg::*;

    t_state r_state, n_state;
    logic   accept, exec;

    logic [CMD_W-1:0] r_cmd;
    t_pool            r_pool;
    t_slot            r_slot;
    t_refs            r_rd;

    t_refs mem [TOTAL_SLOTS];
    logic               mem_we;
    logic [SLOT_AW-1:0] mem_wa;
    t_refs              mem_wd;
    logic [SLOT_AW-1:0] mem_ra;

    logic [TOTAL_SLOTS-1:0] r_in_use, n_in_use;
    t_cnt r_live [NPOOLS];
    t_cnt r_peak [NPOOLS];
    t_cnt n_live [NPOOLS];
    t_cnt n_peak [NPOOLS];

    logic               in_range;
    t_pool              slot_pool;
    logic [SLOT_AW-1:0] slot_addr;
    logic               found;
    logic [OFF_W-1:0]   alloc_off;
    t_slot              alloc_slot;
    t_slot              cand;

    t_status res_status;
    t_slot   res_slot;
    t_refs   res_refs;
    logic    res_freed;
    t_pool   res_pool;
    logic    res_counts;
    t_refs   dec_refs;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_pool <= i_pool_type;
            r_slot <= i_slot_index;
        end
    end

    assign mem_ra = (7'(i_slot_index) < 7'(TOTAL_SLOTS)) ? i_slot_index[SLOT_AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept) begin
            r_rd <= mem[mem_ra];
        end
    end

    assign in_range  = 7'(r_slot) < 7'(TOTAL_SLOTS);
    assign slot_pool = pool_of(r_slot);
    assign slot_addr = in_range ? r_slot[SLOT_AW-1:0] : '0;
    assign dec_refs  = (r_rd != '0) ? r_rd - 1'b1 : r_rd;

    always_comb begin
        found     = 1'b0;
        alloc_off = '0;
        cand      = '0;
        for (int i = POOL_MAX - 1; i >= 0; i--) begin
            cand = (i < int'(pool_size(r_pool))) ? pool_base(r_pool) + SLOT_W'(i)
                                                  : pool_base(r_pool);
            if ((i < int'(pool_size(r_pool))) && !r_in_use[cand[SLOT_AW-1:0]]) begin
                found     = 1'b1;
                alloc_off = OFF_W'(i);
            end
        end
        alloc_slot = pool_base(r_pool) + SLOT_W'(alloc_off);
    end

    always_comb begin
        n_in_use   = r_in_use;
        n_live     = r_live;
        n_peak     = r_peak;
        mem_we     = 1'b0;
        mem_wa     = slot_addr;
        mem_wd     = r_rd;
        res_status = ST_OK;
        res_slot   = '0;
        res_refs   = '0;
        res_freed  = 1'b0;
        res_pool   = r_pool;
        res_counts = 1'b1;
        case (r_cmd)
            CMD_ALLOC: begin
                if (found) begin
                    n_in_use[alloc_slot[SLOT_AW-1:0]] = 1'b1;
                    mem_we   = exec;
                    mem_wa   = alloc_slot[SLOT_AW-1:0];
                    mem_wd   = REF_BITS'(1);
                    n_live[r_pool] = r_live[r_pool] + 1'b1;
                    if (n_live[r_pool] > r_peak[r_pool]) begin
                        n_peak[r_pool] = n_live[r_pool];
                    end
                    res_slot = alloc_slot;
                    res_refs = REF_BITS'(1);
                end else begin
                    res_status = ST_EMPTY;
                end
            end
            CMD_RELEASE, CMD_ADDREF: begin
                res_pool = slot_pool;
                if (!in_range) begin
                    res_status = ST_RANGE;
                    res_pool   = '0;
                    res_counts = 1'b0;
                end else if (!r_in_use[slot_addr]) begin
                    res_status = ST_NOT_ALLOC;
                    res_slot   = r_slot;
                end else if (r_cmd == CMD_RELEASE) begin
                    res_slot = r_slot;
                    mem_we   = exec;
                    mem_wd   = dec_refs;
                    res_refs = dec_refs;
                    if (dec_refs == '0) begin
                        n_in_use[slot_addr] = 1'b0;
                        res_freed = 1'b1;
                        if (r_live[slot_pool] != '0) begin
                            n_live[slot_pool] = r_live[slot_pool] - 1'b1;
                        end
                    end
                end else begin
                    res_slot = r_slot;
                    res_refs = r_rd;
                    if (r_rd == REF_MAX) begin
                        res_status = ST_SAT;
                    end else begin
                        mem_we   = exec;
                        mem_wd   = r_rd + 1'b1;
                        res_refs = r_rd + 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                for (int p = 0; p < NPOOLS; p++) begin
                    n_peak[p] = '0;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            for (int p = 0; p < NPOOLS; p++) begin
                r_live[p] <= '0;
                r_peak[p] <= '0;
            end
        end else if (exec) begin
            r_in_use <= n_in_use;
            r_live   <= n_live;
            r_peak   <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            o_status          <= res_status;
            o_granted_slot    <= res_slot;
            o_ref_count_after <= (32'(res_refs) > 32'd255) ? 8'hFF : REFO_W'(res_refs);
            o_slot_freed      <= res_freed;
            o_pool_reported   <= res_pool;
            o_live_count      <= res_counts ? n_live[res_pool] : '0;
            o_peak_count      <= res_counts ? n_peak[res_pool] : '0;
        end
    end

    a_busy_one_cycle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("command gave no result word");

    a_freed_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slot_freed) |-> (o_ref_count_after == '0 && o_status == ST_OK))
        else $error("freed slot reports a nonzero count");

    a_empty_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |->
            (o_live_count == pool_size(o_pool_reported)))
        else $error("pool reported empty while not full");

    a_range_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANGE) |->
            (o_live_count == '0 && o_pool_reported == '0 && o_granted_slot == '0))
        else $error("out-of-range result carries counts");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import spra_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam t_pool POOL_BASIC    = 2'd0;
    localparam t_pool POOL_DATAGRAM = 2'd1;
    localparam t_pool POOL_SNIP     = 2'd2;
    localparam t_pool POOL_STREAM   = 2'd3;
    localparam int unsigned REFO_CAP = (1 << REFO_W) - 1;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_WORDS = 700;

    typedef struct {
        logic [STATUS_W-1:0] status;
        t_slot               slot;
        logic [REFO_W-1:0]   refs;
        logic                freed;
        t_pool               pool;
        t_cnt                live;
        t_cnt                peak;
    } slot_reply_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [POOL_W-1:0]   i_pool_type;
    logic [SLOT_W-1:0]   i_slot_index;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_granted_slot;
    logic [REFO_W-1:0]   o_ref_count_after;
    logic                o_slot_freed;
    logic [POOL_W-1:0]   o_pool_reported;
    logic [CNT_W-1:0]    o_live_count;
    logic [CNT_W-1:0]    o_peak_count;

    int unsigned pool_len [NPOOLS] = '{BASIC_SLOTS, DATAGRAM_SLOTS, SNIP_SLOTS, STREAM_SLOTS};
    int unsigned pool_first [NPOOLS] = '{0, BASIC_SLOTS, BASIC_SLOTS + DATAGRAM_SLOTS,
                                         BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS};

    bit          mdl_in_use [TOTAL_SLOTS];
    int unsigned mdl_refs [TOTAL_SLOTS];
    int unsigned mdl_live [NPOOLS];
    int unsigned mdl_peak [NPOOLS];

    slot_reply_t replies_due [$];
    int          mismatches;
    int          gap_pct;
    int          idle_cycles;

    segregated_pool_refcount_allocator_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_pool_type       (i_pool_type),
        .i_slot_index      (i_slot_index),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_ref_count_after (o_ref_count_after),
        .o_slot_freed      (o_slot_freed),
        .o_pool_reported   (o_pool_reported),
        .o_live_count      (o_live_count),
        .o_peak_count      (o_peak_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one command word to the slot bookkeeping and returns the word
    // the block must answer with.
    function automatic slot_reply_t predict_reply(logic [CMD_W-1:0] c, t_pool p, t_slot s);
        slot_reply_t r;
        int unsigned owner;
        bit          found;
        r = '{default: '0};
        found = 1'b0;
        case (c)
            CMD_ALLOC: begin
                r.pool = p;
                r.status = ST_EMPTY;
                for (int unsigned i = pool_first[p]; i < pool_first[p] + pool_len[p]; i++) begin
                    if (!found && !mdl_in_use[i]) begin
                        found = 1'b1;
                        mdl_in_use[i] = 1'b1;
                        mdl_refs[i] = 1;
                        mdl_live[p]++;
                        if (mdl_live[p] > mdl_peak[p]) begin
                            mdl_peak[p] = mdl_live[p];
                        end
                        r.status = ST_OK;
                        r.slot = t_slot'(i);
                        r.refs = 1;
                    end
                end
            end
            CMD_RELEASE, CMD_ADDREF: begin
                if (s >= TOTAL_SLOTS) begin
                    r.status = ST_RANGE;
                end else begin
                    owner = NPOOLS - 1;
                    while (owner > 0 && s < pool_first[owner]) begin
                        owner--;
                    end
                    r.slot = s;
                    r.pool = t_pool'(owner);
                    if (!mdl_in_use[s]) begin
                        r.status = ST_NOT_ALLOC;
                    end else if (c == CMD_RELEASE) begin
                        r.status = ST_OK;
                        mdl_refs[s]--;
                        if (mdl_refs[s] == 0) begin
                            mdl_in_use[s] = 1'b0;
                            mdl_live[owner]--;
                            r.freed = 1'b1;
                        end
                    end else if (mdl_refs[s] >= REF_MAX) begin
                        r.status = ST_SAT;
                    end else begin
                        r.status = ST_OK;
                        mdl_refs[s]++;
                    end
                    if (mdl_in_use[s]) begin
                        r.refs = (mdl_refs[s] > REFO_CAP) ? REFO_W'(REFO_CAP)
                                                          : REFO_W'(mdl_refs[s]);
                    end
                end
            end
            CMD_CLEAR: begin
                foreach (mdl_peak[i]) begin
                    mdl_peak[i] = 0;
                end
                r.pool = p;
            end
            default: begin
                r.pool = p;
            end
        endcase
        if (r.status != ST_RANGE) begin
            r.live = t_cnt'(mdl_live[r.pool]);
            r.peak = t_cnt'(mdl_peak[r.pool]);
        end
        return r;
    endfunction

    // Drives one command word, possibly after a random gap, and holds it until
    // the block takes it. start is left high for a following word.
    task automatic send_word(input logic [CMD_W-1:0] c, input t_pool p, input t_slot s);
        int gap;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        i_pool_type <= p;
        i_slot_index <= s;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        replies_due.push_back(predict_reply(c, p, s));
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        slot_reply_t want;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, expected none, got status %0d",
                         $time, o_status);
            end else begin
                want = replies_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("granted_slot", want.slot, o_granted_slot);
                check_field("ref_count_after", want.refs, o_ref_count_after);
                check_field("slot_freed", want.freed, o_slot_freed);
                check_field("pool_reported", want.pool, o_pool_reported);
                check_field("live_count", want.live, o_live_count);
                check_field("peak_count", want.peak, o_peak_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_commands();
        send_word(CMD_REPORT, POOL_BASIC, '0);
        send_word(CMD_ALLOC, POOL_BASIC, '1);
        send_word(CMD_ALLOC, POOL_DATAGRAM, '0);
        send_word(CMD_ADDREF, POOL_STREAM, '0);
        send_word(CMD_RELEASE, POOL_SNIP, '0);
        send_word(CMD_RELEASE, POOL_BASIC, '0);
        send_word(CMD_RELEASE, POOL_BASIC, '0);
        send_word(CMD_ADDREF, POOL_BASIC, t_slot'(1));
        send_word(CMD_RELEASE, POOL_BASIC, t_slot'(TOTAL_SLOTS));
        send_word(CMD_ADDREF, POOL_STREAM, '1);
        send_word(CMD_ALLOC, POOL_SNIP, '0);
        send_word(CMD_ALLOC, POOL_STREAM, '1);
        send_word(CMD_ADDREF, POOL_BASIC, t_slot'(pool_first[POOL_STREAM]));
        send_word(CMD_CLEAR, POOL_DATAGRAM, '1);
        send_word(CMD_REPORT, POOL_DATAGRAM, '0);
        send_word(CMD_SPARE_LO, POOL_SNIP, '0);
        send_word(CMD_SPARE_HI, POOL_STREAM, '1);
        send_word(CMD_RELEASE, POOL_BASIC, t_slot'(TOTAL_SLOTS - 1));
        send_word(CMD_RELEASE, POOL_STREAM, t_slot'(pool_first[POOL_DATAGRAM]));
        send_word(CMD_RELEASE, POOL_BASIC, t_slot'(pool_first[POOL_SNIP]));
        send_word(CMD_ALLOC, POOL_DATAGRAM, '0);
    endtask

    task automatic test_pool_exhaust();
        for (int p = 0; p < NPOOLS; p++) begin
            repeat (pool_len[p] + 1) send_word(CMD_ALLOC, t_pool'(p), t_slot'($urandom_range(63)));
        end
        send_word(CMD_REPORT, POOL_SNIP, '0);
        send_word(CMD_CLEAR, POOL_STREAM, '0);
        send_word(CMD_REPORT, POOL_BASIC, '0);
        for (int s = TOTAL_SLOTS - 1; s >= 0; s--) begin
            while (mdl_in_use[s]) send_word(CMD_RELEASE, t_pool'($urandom_range(3)), t_slot'(s));
        end
        send_word(CMD_REPORT, POOL_STREAM, '0);
    endtask

    task automatic test_saturation();
        t_slot s;
        send_word(CMD_ALLOC, POOL_DATAGRAM, '0);
        s = replies_due[$].slot;
        while (mdl_refs[s] < REF_MAX) send_word(CMD_ADDREF, t_pool'($urandom_range(3)), s);
        repeat (2) send_word(CMD_ADDREF, POOL_STREAM, s);
        while (mdl_in_use[s]) send_word(CMD_RELEASE, t_pool'($urandom_range(3)), s);
        send_word(CMD_RELEASE, POOL_BASIC, s);
    endtask

    function automatic logic [CMD_W-1:0] CMD_CMD_SPARE_PICK();
        return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    task automatic test_random();
        int    phase_pct [4] = '{0, 55, 0, 22};
        int    alloc_w;
        int    roll;
        int    pick;
        int    held [$];
        t_slot s;
        t_pool p;
        alloc_w = 30;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gap_pct = phase_pct[n * 4 / RANDOM_WORDS];
            if (n % 50 == 0) begin
                alloc_w = $urandom_range(15, 50);
            end
            held = {};
            foreach (mdl_in_use[i]) begin
                if (mdl_in_use[i]) held.push_back(i);
            end
            s = t_slot'($urandom_range(63));
            if (held.size() != 0 && $urandom_range(9) != 0) begin
                s = t_slot'(held[$urandom_range(held.size() - 1)]);
            end
            p = t_pool'($urandom_range(3));
            roll = $urandom_range(99);
            if (roll < alloc_w) begin
                send_word(CMD_ALLOC, p, s);
            end else if (roll < alloc_w + 32) begin
                send_word(CMD_RELEASE, p, s);
            end else if (roll < alloc_w + 45) begin
                send_word(CMD_ADDREF, p, s);
            end else begin
                pick = $urandom_range(3);
                if (pick == 0) begin
                    send_word(CMD_CLEAR, p, s);
                end else if (pick == 3) begin
                    send_word(CMD_CMD_SPARE_PICK(), p, s);
                end else begin
                    send_word(CMD_REPORT, p, s);
                end
            end
        end
        gap_pct = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= CMD_ALLOC;
        i_pool_type <= POOL_BASIC;
        i_slot_index <= '0;
        gap_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_commands();
        test_pool_exhaust();
        test_saturation();
        test_random();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spra_pkg.sv
sv/segregated_pool_refcount_allocator_core.sv
bench/tb.sv
